@@ sv/mtc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_pkg: shared types and tables of the Morse text codec
// Morse code table, job word passed from front to back, character codes.
// ----------------------------------------------------------------------------
package mtc_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;

    // Direction register codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam int NUM_LETTERS = 26;
    localparam int NUM_CODES   = 36;
    localparam int MAX_SYMBOLS = 5;

    // Default depth of the job queue between front and back
    localparam int JOB_DEPTH_DEFAULT = 2;

    // Morse codes as {length[2:0], pattern[4:0]}; symbol i in bit i, 1 = dash.
    // Letters A..Z, then digits 0..9.
    localparam logic [7:0] MORSE_CODE [NUM_CODES] = '{
        {3'd2, 5'b00010}, {3'd4, 5'b00001}, {3'd4, 5'b00101}, {3'd3, 5'b00001},
        {3'd1, 5'b00000}, {3'd4, 5'b00100}, {3'd3, 5'b00011}, {3'd4, 5'b00000},
        {3'd2, 5'b00000}, {3'd4, 5'b01110}, {3'd3, 5'b00101}, {3'd4, 5'b00010},
        {3'd2, 5'b00011}, {3'd2, 5'b00001}, {3'd3, 5'b00111}, {3'd4, 5'b00110},
        {3'd4, 5'b01011}, {3'd3, 5'b00010}, {3'd3, 5'b00000}, {3'd1, 5'b00001},
        {3'd3, 5'b00100}, {3'd4, 5'b01000}, {3'd3, 5'b00110}, {3'd4, 5'b01001},
        {3'd4, 5'b01101}, {3'd4, 5'b00011},
        {3'd5, 5'b11111}, {3'd5, 5'b11110}, {3'd5, 5'b11100}, {3'd5, 5'b11000},
        {3'd5, 5'b10000}, {3'd5, 5'b00000}, {3'd5, 5'b00001}, {3'd5, 5'b00011},
        {3'd5, 5'b00111}, {3'd5, 5'b01111}
    };

    // Kind of work handed to the back end
    typedef enum logic {
        JOB_SYMBOLS,    // emit a Morse code symbol by symbol, then a space
        JOB_SINGLE      // emit exactly one result word
    } job_kind_t;

    // One job word in the queue
    typedef struct packed {
        job_kind_t   kind;
        logic [4:0]  pattern;
        logic [2:0]  length;
        logic [7:0]  ch;
        logic        valid;
        logic        err;
        logic        eom;
    } job_t;

    // Result of a token lookup
    typedef struct packed {
        logic       hit;
        logic [7:0] ch;
    } lookup_t;

    // Table index to its uppercase letter or digit
    function automatic logic [7:0] index_char(input logic [5:0] idx);
        logic [7:0] r;
        if (idx < 6'(NUM_LETTERS))
        begin
            r = CH_UPPER_A + {2'b00, idx};
        end
        else
        begin
            r = CH_DIGIT_0 + {2'b00, idx} - 8'(NUM_LETTERS);
        end
        return r;
    endfunction

    // Pending token to its character; parallel compare against every code
    function automatic lookup_t token_lookup(input logic [2:0] len, input logic [4:0] pat);
        lookup_t r;
        r.hit = 1'b0;
        r.ch  = CH_NUL;
        for (int i = 0; i < NUM_CODES; i++)
        begin
            if (MORSE_CODE[i] == {len, pat})
            begin
                r.hit = 1'b1;
                r.ch  = index_char(6'(i));
            end
        end
        return r;
    endfunction

endpackage

@@ sv/mtc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_front: input classifier of the Morse text codec
// One byte a cycle on accept; keeps token and error state, issues job words.
// ----------------------------------------------------------------------------
module mtc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    input  logic          cfg_direction,
    input  logic          accept,
    input  logic [7:0]    char_in,
    input  logic          end_of_message,
    output logic          job_push,
    output mtc_pkg::job_t job
);
    import mtc_pkg::*;

    logic       direction_reg;
    logic [4:0] tok_pat_reg, tok_pat_next;
    logic [2:0] tok_len_reg, tok_len_next;
    logic       err_reg, err_next;

    logic       have;
    logic       is_sym;
    logic       is_dash;
    logic       enc_hit;
    logic [5:0] enc_idx;
    logic [4:0] new_pat;
    logic [2:0] new_len;
    lookup_t    lk;

    // Direction register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_ENCODE;
        end
        else if (cfg_valid)
        begin
            direction_reg <= cfg_direction;
        end
    end

    // Encode classification: letter of either case or digit
    always_comb
    begin
        enc_hit = 1'b1;
        enc_idx = '0;
        if (char_in >= CH_LOWER_A && char_in <= CH_LOWER_Z)
        begin
            enc_idx = 6'(char_in - CH_LOWER_A);
        end
        else if (char_in >= CH_UPPER_A && char_in <= CH_UPPER_Z)
        begin
            enc_idx = 6'(char_in - CH_UPPER_A);
        end
        else if (char_in >= CH_DIGIT_0 && char_in <= CH_DIGIT_9)
        begin
            enc_idx = 6'(char_in - CH_DIGIT_0) + 6'(NUM_LETTERS);
        end
        else
        begin
            enc_hit = 1'b0;
        end
    end

    // Token extension and lookup of the token being flushed
    assign is_dash = (char_in == CH_DASH);
    assign is_sym  = is_dash || (char_in == CH_DOT);
    assign new_pat = tok_pat_reg | (5'(is_dash) << tok_len_reg);
    assign new_len = tok_len_reg + 3'd1;
    assign lk      = is_sym ? token_lookup(new_len, new_pat)
                            : token_lookup(tok_len_reg, tok_pat_reg);

    // Classification and next token state
    always_comb
    begin
        have         = 1'b0;
        job          = '0;
        job.kind     = JOB_SINGLE;
        job.eom      = end_of_message;
        tok_pat_next = tok_pat_reg;
        tok_len_next = tok_len_reg;
        err_next     = err_reg;

        if (!err_reg)
        begin
            if (direction_reg == DIR_ENCODE)
            begin
                have = 1'b1;
                if (enc_hit)
                begin
                    job.kind    = JOB_SYMBOLS;
                    job.length  = MORSE_CODE[enc_idx][7:5];
                    job.pattern = MORSE_CODE[enc_idx][4:0];
                end
                else
                begin
                    job.err  = 1'b1;
                    err_next = 1'b1;
                end
            end
            else if (is_sym)
            begin
                if (tok_len_reg >= 3'(MAX_SYMBOLS))
                begin
                    // overlong token
                    have         = 1'b1;
                    job.err      = 1'b1;
                    err_next     = 1'b1;
                    tok_pat_next = '0;
                    tok_len_next = '0;
                end
                else if (end_of_message)
                begin
                    have         = 1'b1;
                    job.ch       = lk.ch;
                    job.valid    = lk.hit;
                    job.err      = !lk.hit;
                    err_next     = !lk.hit;
                    tok_pat_next = '0;
                    tok_len_next = '0;
                end
                else
                begin
                    tok_pat_next = new_pat;
                    tok_len_next = new_len;
                end
            end
            else if (char_in == CH_SPACE)
            begin
                if (tok_len_reg != 3'd0)
                begin
                    have         = 1'b1;
                    job.ch       = lk.ch;
                    job.valid    = lk.hit;
                    job.err      = !lk.hit;
                    err_next     = !lk.hit;
                    tok_pat_next = '0;
                    tok_len_next = '0;
                end
            end
            else
            begin
                have         = 1'b1;
                job.err      = 1'b1;
                err_next     = 1'b1;
                tok_pat_next = '0;
                tok_len_next = '0;
            end
        end

        // end marker so the message end is always seen; then clear token and error state
        if (end_of_message)
        begin
            have         = 1'b1;
            tok_pat_next = '0;
            tok_len_next = '0;
            err_next     = 1'b0;
        end
    end

    assign job_push = accept && have;

    // Token and error state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_pat_reg <= '0;
            tok_len_reg <= '0;
            err_reg     <= 1'b0;
        end
        else if (accept)
        begin
            tok_pat_reg <= tok_pat_next;
            tok_len_reg <= tok_len_next;
            err_reg     <= err_next;
        end
    end

endmodule

@@ sv/mtc_job_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_job_fifo: job queue between front and back
// Small show-ahead FIFO of job words; head word is visible while not empty.
// ----------------------------------------------------------------------------
module mtc_job_fifo #(
    parameter int DEPTH = mtc_pkg::JOB_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  mtc_pkg::job_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output mtc_pkg::job_t rd_data,
    output logic          empty
);
    import mtc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

@@ sv/mtc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_back: result sequencer of the Morse text codec
// Expands jobs to result words in an output register, one a cycle unless held.
// ----------------------------------------------------------------------------
module mtc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  mtc_pkg::job_t job,
    output logic          job_pop,
    output logic          empty,
    input  logic          pop,
    output logic [7:0]    char_out,
    output logic          char_valid,
    output logic          error,
    output logic          last_of_run,
    output logic          message_end
);
    import mtc_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [2:0] step_reg, step_next;
    logic [7:0] ch_reg, ch_next;
    logic       val_reg, val_next;
    logic       err_reg, err_next;
    logic       last_reg, last_next;
    logic       me_reg, me_next;
    logic       advance;

    // Output register is free when empty or being taken
    assign advance = !out_valid_reg || pop;

    // Next result word from the head job
    always_comb
    begin
        job_pop        = 1'b0;
        out_valid_next = out_valid_reg;
        step_next      = step_reg;
        ch_next        = ch_reg;
        val_next       = val_reg;
        err_next       = err_reg;
        last_next      = last_reg;
        me_next        = me_reg;
        if (advance)
        begin
            out_valid_next = job_valid;
            if (job_valid)
            begin
                unique case (job.kind)
                    JOB_SYMBOLS:
                    begin
                        val_next = 1'b1;
                        err_next = 1'b0;
                        if (step_reg < job.length)
                        begin
                            ch_next   = job.pattern[step_reg] ? CH_DASH : CH_DOT;
                            last_next = 1'b0;
                            me_next   = 1'b0;
                            step_next = step_reg + 3'd1;
                        end
                        else
                        begin
                            // trailing space closes the character
                            ch_next   = CH_SPACE;
                            last_next = 1'b1;
                            me_next   = job.eom;
                            step_next = '0;
                            job_pop   = 1'b1;
                        end
                    end
                    JOB_SINGLE:
                    begin
                        ch_next   = job.ch;
                        val_next  = job.valid;
                        err_next  = job.err;
                        last_next = 1'b1;
                        me_next   = job.eom;
                        job_pop   = 1'b1;
                    end
                    default:
                    begin
                        job_pop = 1'b0;
                    end
                endcase
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        val_reg  <= val_next;
        err_reg  <= err_next;
        last_reg <= last_next;
        me_reg   <= me_next;
    end

    assign empty       = !out_valid_reg;
    assign char_out    = ch_reg;
    assign char_valid  = val_reg;
    assign error       = err_reg;
    assign last_of_run = last_reg;
    assign message_end = me_reg;

endmodule

@@ sv/morse_text_codec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_text_codec: ASCII to Morse encoder and Morse to ASCII decoder
// Front end classifies bytes and keeps token state; back end emits results.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     push / full            char_in, end_of_message
//  result    empty / pop            char_out, char_valid, error,
//                                   last_of_run, message_end
//  config    cfg_valid / cfg_ready  cfg_direction
//
//  The front end takes one byte per cycle while the job queue has room.
//  Encoding a character gives a result word per symbol and a trailing space,
//  one a cycle from the back-end sequencer unless pop stalls; a decode or
//  error job gives one word. Results pass the queue, then the output register.
//  Reset clears token, error and direction state and empties both stages.
//  A stalled pop holds the result register and, once the queue fills, full.
// ----------------------------------------------------------------------------
module morse_text_codec #(
    parameter int JOB_DEPTH = mtc_pkg::JOB_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] char_in,
    input  logic       end_of_message,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] char_out,
    output logic       char_valid,
    output logic       error,
    output logic       last_of_run,
    output logic       message_end,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_direction
);
    import mtc_pkg::*;

    logic accept;
    logic job_push;
    job_t job_in;
    job_t job_head;
    logic job_empty;
    logic job_pop;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    // Front: classify bytes
    mtc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_direction  (cfg_direction),
        .accept         (accept),
        .char_in        (char_in),
        .end_of_message (end_of_message),
        .job_push       (job_push),
        .job            (job_in)
    );

    // Job queue
    mtc_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (full),
        .rd_en   (job_pop),
        .rd_data (job_head),
        .empty   (job_empty)
    );

    // Back: emit result words
    mtc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (!job_empty),
        .job         (job_head),
        .job_pop     (job_pop),
        .empty       (empty),
        .pop         (pop),
        .char_out    (char_out),
        .char_valid  (char_valid),
        .error       (error),
        .last_of_run (last_of_run),
        .message_end (message_end)
    );

    // Error words carry no character
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && error |-> !char_valid && char_out == CH_NUL)
        else $error("error word carries a character");

    // Message end only closes the run of an input byte
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && message_end |-> last_of_run)
        else $error("message end on a word that is not last of run");

    // A symbol word is always followed by more words of the same run
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !last_of_run |=> !job_empty || !empty)
        else $error("run ended without its last word");

endmodule

@@ tb/tb_morse_text_codec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_morse_text_codec: self-checking testbench of the Morse text codec
// Drives bytes through the push/full side, predicts every result word from
// its own model of the codec and checks each popped word field by field.
// Covers both directions, error latching, end markers, direction changes
// inside a message, a long receiver stall and random message traffic.
// ----------------------------------------------------------------------------
module tb_morse_text_codec;

    import mtc_pkg::*;

    // One result word as the codec should present it
    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       err;
        logic       last;
        logic       eom;
    } morse_word_t;

    // Receiver pop patterns
    typedef enum logic [1:0] {
        RX_STREAM,      // pop every cycle
        RX_COIN,        // pop half the time
        RX_SLOW,        // pop when rx_tick is a multiple of four
        RX_MOSTLY       // pop four times in five, at random
    } rx_mode_t;

    localparam int RANDOM_ITEMS   = 320;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 200;

    // DUT ports
    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] char_in;
    logic       end_of_message;
    logic       empty;
    logic       pop;
    logic [7:0] char_out;
    logic       char_valid;
    logic       error;
    logic       last_of_run;
    logic       message_end;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_direction;

    // Predictor state
    logic       codec_dir;
    logic [4:0] tok_pattern;
    logic [2:0] tok_length;
    logic       err_hold;

    morse_word_t expected_words [$];
    morse_word_t seen_word;

    int fail_count;
    int items_sent;
    int burst_left;
    int rx_hold;
    int rx_left;
    int rx_tick;
    rx_mode_t rx_mode;

    morse_text_codec DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .char_in        (char_in),
        .end_of_message (end_of_message),
        .empty          (empty),
        .pop            (pop),
        .char_out       (char_out),
        .char_valid     (char_valid),
        .error          (error),
        .last_of_run    (last_of_run),
        .message_end    (message_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_direction  (cfg_direction)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Hard limit on the run
    initial
    begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Dots and dashes of letters A..Z, then digits 0..9
    function automatic string morse_of(input int idx);
        string s;
        case (idx)
            0:  s = ".-";     1:  s = "-...";   2:  s = "-.-.";   3:  s = "-..";
            4:  s = ".";      5:  s = "..-.";   6:  s = "--.";    7:  s = "....";
            8:  s = "..";     9:  s = ".---";   10: s = "-.-";    11: s = ".-..";
            12: s = "--";     13: s = "-.";     14: s = "---";    15: s = ".--.";
            16: s = "--.-";   17: s = ".-.";    18: s = "...";    19: s = "-";
            20: s = "..-";    21: s = "...-";   22: s = ".--";    23: s = "-..-";
            24: s = "-.--";   25: s = "--..";
            26: s = "-----";  27: s = ".----";  28: s = "..---";  29: s = "...--";
            30: s = "....-";  31: s = ".....";  32: s = "-....";  33: s = "--...";
            34: s = "---..";  default: s = "----.";
        endcase
        return s;
    endfunction

    function automatic morse_word_t make_word(input logic [7:0] ch, input logic valid,
                                              input logic err);
        morse_word_t w;
        w.ch    = ch;
        w.valid = valid;
        w.err   = err;
        w.last  = 1'b0;
        w.eom   = 1'b0;
        return w;
    endfunction

    // Table index of a token, -1 when no letter or digit matches
    function automatic int find_code(input logic [2:0] len, input logic [4:0] pat);
        int hit;
        string code;
        logic [4:0] p;
        hit = -1;
        for (int i = 0; i < NUM_CODES; i++)
        begin
            code = morse_of(i);
            p = '0;
            for (int n = 0; n < code.len(); n++)
            begin
                if (code[n] == CH_DASH)
                begin
                    p[n] = 1'b1;
                end
            end
            if (code.len() == int'(len) && p == pat)
            begin
                hit = i;
            end
        end
        return hit;
    endfunction

    // Pending token to one word; clears the token
    function automatic morse_word_t flush_token();
        int idx;
        morse_word_t w;
        idx = find_code(tok_length, tok_pattern);
        tok_pattern = '0;
        tok_length  = '0;
        if (idx < 0)
        begin
            err_hold = 1'b1;
            w = make_word(CH_NUL, 1'b0, 1'b1);
        end
        else if (idx < NUM_LETTERS)
        begin
            w = make_word(CH_UPPER_A + 8'(idx), 1'b1, 1'b0);
        end
        else
        begin
            w = make_word(CH_DIGIT_0 + 8'(idx - NUM_LETTERS), 1'b1, 1'b0);
        end
        return w;
    endfunction

    // Expected words of one accepted byte, appended to expected_words
    task automatic predict_item(input logic [7:0] c, input logic e);
        morse_word_t run [$];
        int idx;
        string code;
        idx = -1;
        if (!err_hold)
        begin
            if (codec_dir == DIR_ENCODE)
            begin
                if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
                    idx = int'(c - CH_LOWER_A);
                else if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
                    idx = int'(c - CH_UPPER_A);
                else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
                    idx = int'(c - CH_DIGIT_0) + NUM_LETTERS;
                if (idx < 0)
                begin
                    err_hold = 1'b1;
                    run.push_back(make_word(CH_NUL, 1'b0, 1'b1));
                end
                else
                begin
                    code = morse_of(idx);
                    for (int n = 0; n < code.len(); n++)
                    begin
                        run.push_back(make_word(code[n], 1'b1, 1'b0));
                    end
                    run.push_back(make_word(CH_SPACE, 1'b1, 1'b0));
                end
            end
            else if (c == CH_DOT || c == CH_DASH)
            begin
                // a sixth symbol overflows the token
                if (tok_length >= MAX_SYMBOLS)
                begin
                    tok_pattern = '0;
                    tok_length  = '0;
                    err_hold    = 1'b1;
                    run.push_back(make_word(CH_NUL, 1'b0, 1'b1));
                end
                else
                begin
                    if (c == CH_DASH)
                        tok_pattern[tok_length] = 1'b1;
                    tok_length++;
                    if (e)
                        run.push_back(flush_token());
                end
            end
            else if (c == CH_SPACE)
            begin
                if (tok_length != 0)
                    run.push_back(flush_token());
            end
            else
            begin
                tok_pattern = '0;
                tok_length  = '0;
                err_hold    = 1'b1;
                run.push_back(make_word(CH_NUL, 1'b0, 1'b1));
            end
        end
        // end marker so the message end is always seen
        if (e && run.size() == 0)
            run.push_back(make_word(CH_NUL, 1'b0, 1'b0));
        if (run.size() > 0)
        begin
            run[run.size() - 1].last = 1'b1;
            run[run.size() - 1].eom  = e;
        end
        if (e)
        begin
            tok_pattern = '0;
            tok_length  = '0;
            err_hold    = 1'b0;
        end
        foreach (run[k])
            expected_words.push_back(run[k]);
    endtask

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one byte until taken; bursts end in a random gap
    task automatic send_item(input logic [7:0] c, input logic e);
        int gap;
        push           <= 1'b1;
        char_in        <= c;
        end_of_message <= e;
        do
            @(posedge clk);
        while (full);
        predict_item(c, e);
        items_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop offering and wait until every expected word has been popped
    task automatic settle();
        push <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        // a byte without results may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_direction(input logic d);
        settle();
        cfg_valid     <= 1'b1;
        cfg_direction <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        codec_dir = d;
    endtask

    // Printable letter or digit, now and then any byte
    function automatic logic [7:0] pick_text_char();
        logic [7:0] c;
        case ($urandom_range(0, 12))
            0:       c = 8'($urandom_range(0, 255));
            1, 2, 3: c = CH_DIGIT_0 + 8'($urandom_range(0, 9));
            4, 5, 6: c = CH_LOWER_A + 8'($urandom_range(0, 25));
            default: c = CH_UPPER_A + 8'($urandom_range(0, 25));
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Letters of both cases, digits, bad bytes, suppression, end marker
    task automatic test_encode_basics();
        set_direction(DIR_ENCODE);
        send_item(CH_UPPER_A, 1'b0);
        send_item(CH_LOWER_Z, 1'b0);
        send_item(CH_DIGIT_9, 1'b0);
        send_item(8'h23, 1'b0);         // '#': error, then silence
        send_item(CH_UPPER_A + 8'd1, 1'b0);
        send_item(CH_LOWER_A + 8'd16, 1'b1);
        send_item(8'hFF, 1'b1);
        send_item(CH_UPPER_Z, 1'b1);
        settle();
    endtask

    // Token build, spaces, five-symbol digit, overflow, unknown code, bad byte
    task automatic test_decode_basics();
        set_direction(DIR_DECODE);
        send_item(CH_DASH, 1'b0);
        send_item(CH_DOT, 1'b0);
        send_item(CH_SPACE, 1'b0);
        send_item(CH_SPACE, 1'b0);      // nothing pending
        repeat (4) send_item(CH_DASH, 1'b0);
        send_item(CH_DASH, 1'b1);       // "-----" closed by end of message
        repeat (6) send_item(CH_DOT, 1'b0);
        send_item(CH_SPACE, 1'b1);      // suppressed: end marker only
        send_item(CH_DOT, 1'b0);
        send_item(CH_DOT, 1'b0);
        send_item(CH_DASH, 1'b0);
        send_item(CH_DASH, 1'b0);
        send_item(CH_SPACE, 1'b1);      // "..--" is no code
        send_item(CH_SPACE, 1'b1);
        send_item(8'h00, 1'b1);
        settle();
    endtask

    // Token survives a trip through encode mode
    task automatic test_direction_switch();
        set_direction(DIR_DECODE);
        send_item(CH_DOT, 1'b0);
        send_item(CH_DASH, 1'b0);
        set_direction(DIR_ENCODE);
        send_item(CH_UPPER_A + 8'd4, 1'b0);
        set_direction(DIR_DECODE);
        send_item(CH_SPACE, 1'b1);
        settle();
    endtask

    // Receiver holds off while the sender keeps pushing until full
    task automatic test_backpressure();
        set_direction(DIR_ENCODE);
        rx_hold = LONG_HOLD;
        repeat (16) send_item(CH_DIGIT_0 + 8'($urandom_range(0, 9)), 1'b0);
        send_item(CH_UPPER_A + 8'($urandom_range(0, 25)), 1'b1);
        settle();
    endtask

    // Random messages: mostly well formed, some noise and broken tokens
    task automatic test_random_messages();
        logic [7:0] msg [$];
        string code;
        int stop_at;
        int units;
        int sw;
        int n;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            msg = {};
            if ($urandom_range(0, 1) != codec_dir || $urandom_range(0, 3) == 0)
                set_direction(1'($urandom_range(0, 1)));
            units = $urandom_range(1, 8);
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: any byte, message ends at random
                for (int k = 0; k < 2 * units; k++)
                    send_item(8'($urandom_range(0, 255)),
                              k == 2 * units - 1 || $urandom_range(0, 4) == 0);
            end
            else
            begin
                for (int u = 0; u < units; u++)
                begin
                    if (codec_dir == DIR_ENCODE)
                    begin
                        msg.push_back(pick_text_char());
                    end
                    else
                    begin
                        case ($urandom_range(0, 9))
                            0:
                            begin
                                msg.push_back(8'($urandom_range(0, 255)));
                            end
                            1:
                            begin
                                n = $urandom_range(1, 6);
                                repeat (n)
                                    msg.push_back($urandom_range(0, 1) ? CH_DASH : CH_DOT);
                            end
                            default:
                            begin
                                code = morse_of($urandom_range(0, NUM_CODES - 1));
                                for (int k = 0; k < code.len(); k++)
                                    msg.push_back(code[k]);
                            end
                        endcase
                        if (u != units - 1 || $urandom_range(0, 2) == 0)
                        begin
                            n = $urandom_range(1, 3);
                            repeat (n) msg.push_back(CH_SPACE);
                        end
                    end
                end
                sw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, msg.size() - 1) : -1;
                foreach (msg[i])
                begin
                    if (i == sw)
                        set_direction(~codec_dir);
                    send_item(msg[i], i == msg.size() - 1);
                end
            end
            // now and then hold the sender until every word is back
            if ($urandom_range(0, 3) == 0)
                settle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------------

    // Pop pattern, with a long hold on request
    initial
    begin
        pop     = 1'b0;
        rx_hold = 0;
        rx_left = 0;
        rx_tick = 0;
        rx_mode = RX_STREAM;
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                pop <= 1'b0;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    rx_left = $urandom_range(20, 80);
                end
                rx_left--;
                rx_tick++;
                case (rx_mode)
                    RX_STREAM: pop <= 1'b1;
                    RX_COIN:   pop <= 1'($urandom_range(0, 1));
                    RX_SLOW:   pop <= (rx_tick % 4 == 0);
                    default:   pop <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Compare each popped word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_words.size() == 0)
            begin
                $error("char_out: no word expected, got 0x%0h", char_out);
                fail_count++;
            end
            else
            begin
                seen_word = expected_words.pop_front();
                check_field("char_out", seen_word.ch, char_out);
                check_field("char_valid", seen_word.valid, char_valid);
                check_field("error", seen_word.err, error);
                check_field("last_of_run", seen_word.last, last_of_run);
                check_field("message_end", seen_word.eom, message_end);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        push           = 1'b0;
        char_in        = '0;
        end_of_message = 1'b0;
        cfg_valid      = 1'b0;
        cfg_direction  = DIR_ENCODE;
        codec_dir      = DIR_ENCODE;
        tok_pattern    = '0;
        tok_length     = '0;
        err_hold       = 1'b0;
        fail_count     = 0;
        items_sent     = 0;
        burst_left     = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_encode_basics();
        test_decode_basics();
        test_direction_switch();
        test_backpressure();
        test_random_messages();

        settle();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
